// ===== sv/slxfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package slxfp_pkg;

    localparam int MAX_PAYLOAD_DEF = 32;
    localparam int FRAME_OVERHEAD  = 4;
    localparam int LEN_W           = 7;
    localparam int COUNT_W         = 6;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_START = 3'd1,
        ST_TOO_LONG  = 3'd2,
        ST_TRUNC     = 3'd3,
        ST_BAD_SUM   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_TYPE,
        PH_LEN,
        PH_DATA,
        PH_CHECK,
        PH_EMIT_RD,
        PH_EMIT_WR
    } phase_t;

    typedef enum logic [1:0] {
        OS_ERR,
        OS_EMPTY,
        OS_ITEM
    } out_sel_t;

    typedef struct packed {
        logic     cap_type;
        logic     cap_len;
        logic     store_byte;
        logic     cap_check;
        logic     emit_start;
        logic     emit_next;
        logic     rd_req;
        logic     load_out;
        out_sel_t out_sel;
        status_t  err_code;
    } cmd_t;

    typedef struct packed {
        logic start_ok;
        logic len_over;
        logic rx_zero;
        logic held_zero;
        logic count_done;
        logic sum_ok;
        logic emit_last;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

// ===== sv/slxfp_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module slxfp_ctrl
    import slxfp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  wire logic  buffer_start,
    input  wire logic  buffer_end,
    input  wire stat_t stat,
    output logic       in_stall,
    output cmd_t       cmd
);

    phase_t state_reg;
    phase_t state_next;
    logic   in_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PH_WAIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        in_stall   = (state_reg == PH_EMIT_RD) || (state_reg == PH_EMIT_WR) || !stat.out_free;
        in_fire    = in_valid && !in_stall;
        cmd        = '0;
        cmd.out_sel  = OS_ERR;
        cmd.err_code = ST_OK;
        state_next = state_reg;

        if (in_fire && buffer_start)
        begin
            if (buffer_end)
            begin
                cmd.load_out = 1'b1;
                cmd.err_code = ST_TRUNC;
                state_next   = PH_WAIT;
            end
            else if (!stat.start_ok)
            begin
                cmd.load_out = 1'b1;
                cmd.err_code = ST_BAD_START;
                state_next   = PH_WAIT;
            end
            else
            begin
                state_next = PH_TYPE;
            end
        end
        else
        begin
            unique case (state_reg)
                PH_WAIT:
                begin
                end
                PH_TYPE:
                begin
                    if (in_fire)
                    begin
                        if (buffer_end)
                        begin
                            cmd.load_out = 1'b1;
                            cmd.err_code = ST_TRUNC;
                            state_next   = PH_WAIT;
                        end
                        else
                        begin
                            cmd.cap_type = 1'b1;
                            state_next   = PH_LEN;
                        end
                    end
                end
                PH_LEN:
                begin
                    if (in_fire)
                    begin
                        if (buffer_end)
                        begin
                            cmd.load_out = 1'b1;
                            cmd.err_code = ST_TRUNC;
                            state_next   = PH_WAIT;
                        end
                        else if (stat.len_over)
                        begin
                            cmd.load_out = 1'b1;
                            cmd.err_code = ST_TOO_LONG;
                            state_next   = PH_WAIT;
                        end
                        else
                        begin
                            cmd.cap_len = 1'b1;
                            state_next  = stat.rx_zero ? PH_CHECK : PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    if (in_fire)
                    begin
                        if (buffer_end)
                        begin
                            cmd.load_out = 1'b1;
                            cmd.err_code = ST_TRUNC;
                            state_next   = PH_WAIT;
                        end
                        else
                        begin
                            cmd.store_byte = 1'b1;
                            if (stat.count_done)
                            begin
                                state_next = PH_CHECK;
                            end
                        end
                    end
                end
                PH_CHECK:
                begin
                    if (in_fire)
                    begin
                        cmd.cap_check = 1'b1;
                        if (!stat.sum_ok)
                        begin
                            cmd.load_out = 1'b1;
                            cmd.err_code = ST_BAD_SUM;
                            state_next   = PH_WAIT;
                        end
                        else if (stat.held_zero)
                        begin
                            cmd.load_out = 1'b1;
                            cmd.out_sel  = OS_EMPTY;
                            state_next   = PH_WAIT;
                        end
                        else
                        begin
                            cmd.emit_start = 1'b1;
                            state_next     = PH_EMIT_RD;
                        end
                    end
                end
                PH_EMIT_RD:
                begin
                    cmd.rd_req = 1'b1;
                    state_next = PH_EMIT_WR;
                end
                PH_EMIT_WR:
                begin
                    if (stat.out_free)
                    begin
                        cmd.load_out  = 1'b1;
                        cmd.out_sel   = OS_ITEM;
                        cmd.emit_next = 1'b1;
                        state_next    = stat.emit_last ? PH_WAIT : PH_EMIT_RD;
                    end
                end
                default:
                begin
                    state_next = PH_WAIT;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/slxfp_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module slxfp_dp
    import slxfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    input  wire logic [7:0] rx_byte,
    input  wire logic       out_stall,
    input  wire cmd_t       cmd,
    output stat_t           stat,
    output logic            out_valid,
    output logic [2:0]      status,
    output logic [7:0]      frame_type,
    output logic [5:0]      payload_count,
    output logic [7:0]      data_byte,
    output logic [4:0]      byte_index,
    output logic            byte_valid,
    output logic [7:0]      check_value,
    output logic [5:0]      frame_length,
    output logic            last
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [7:0]         start_value_reg;
    logic [7:0]         type_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [COUNT_W-1:0] bc_reg;
    logic [COUNT_W-1:0] bc_next;
    logic [7:0]         xor_reg;
    logic [7:0]         check_reg;
    logic [COUNT_W-1:0] k_reg;
    logic [7:0]         mem_q_reg;
    logic [7:0]         mem [MAX_PAYLOAD];

    logic               out_valid_reg;
    status_t            status_reg;
    logic [7:0]         type_out_reg;
    logic [5:0]         count_out_reg;
    logic [7:0]         data_out_reg;
    logic [4:0]         index_out_reg;
    logic               bvalid_out_reg;
    logic [7:0]         check_out_reg;
    logic [5:0]         flen_out_reg;
    logic               last_out_reg;

    logic [5:0]         flen_ok;

    assign bc_next = bc_reg + COUNT_W'(1);
    assign flen_ok = 6'(len_reg + LEN_W'(FRAME_OVERHEAD));

    always_comb
    begin
        stat.start_ok   = (rx_byte == start_value_reg);
        stat.len_over   = (rx_byte > 8'(MAX_PAYLOAD));
        stat.rx_zero    = (rx_byte == 8'd0);
        stat.held_zero  = (len_reg == '0);
        stat.count_done = ({1'b0, bc_next} >= len_reg);
        stat.sum_ok     = (rx_byte == xor_reg);
        stat.emit_last  = (LEN_W'(k_reg) + LEN_W'(1) == len_reg);
        stat.out_free   = !out_valid_reg || !out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_value_reg <= '0;
            type_reg        <= '0;
            len_reg         <= '0;
            bc_reg          <= '0;
            xor_reg         <= '0;
            check_reg       <= '0;
            k_reg           <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                start_value_reg <= cfg_wr_data;
            end
            if (cmd.cap_type)
            begin
                type_reg <= rx_byte;
                xor_reg  <= rx_byte;
            end
            if (cmd.cap_len)
            begin
                len_reg <= rx_byte[LEN_W-1:0];
                bc_reg  <= '0;
            end
            if (cmd.store_byte)
            begin
                xor_reg <= xor_reg ^ rx_byte;
                bc_reg  <= bc_next;
            end
            if (cmd.cap_check)
            begin
                check_reg <= rx_byte;
            end
            if (cmd.emit_start)
            begin
                k_reg <= '0;
            end
            else if (cmd.emit_next)
            begin
                k_reg <= k_reg + COUNT_W'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_byte)
        begin
            mem[bc_reg[AW-1:0]] <= rx_byte;
        end
        if (cmd.rd_req)
        begin
            mem_q_reg <= mem[k_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            case (cmd.out_sel)
                OS_EMPTY:
                begin
                    status_reg     <= ST_OK;
                    type_out_reg   <= type_reg;
                    count_out_reg  <= 6'(len_reg);
                    data_out_reg   <= '0;
                    index_out_reg  <= '0;
                    bvalid_out_reg <= 1'b0;
                    check_out_reg  <= rx_byte;
                    flen_out_reg   <= flen_ok;
                    last_out_reg   <= 1'b1;
                end
                OS_ITEM:
                begin
                    status_reg     <= ST_OK;
                    type_out_reg   <= type_reg;
                    count_out_reg  <= 6'(len_reg);
                    data_out_reg   <= mem_q_reg;
                    index_out_reg  <= k_reg[4:0];
                    bvalid_out_reg <= 1'b1;
                    check_out_reg  <= check_reg;
                    flen_out_reg   <= flen_ok;
                    last_out_reg   <= stat.emit_last;
                end
                default:
                begin
                    status_reg     <= cmd.err_code;
                    type_out_reg   <= '0;
                    count_out_reg  <= '0;
                    data_out_reg   <= '0;
                    index_out_reg  <= '0;
                    bvalid_out_reg <= 1'b0;
                    check_out_reg  <= '0;
                    flen_out_reg   <= '0;
                    last_out_reg   <= 1'b1;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign frame_type    = type_out_reg;
    assign payload_count = count_out_reg;
    assign data_byte     = data_out_reg;
    assign byte_index    = index_out_reg;
    assign byte_valid    = bvalid_out_reg;
    assign check_value   = check_out_reg;
    assign frame_length  = flen_out_reg;
    assign last          = last_out_reg;

endmodule

`default_nettype wire

// ===== sv/sof_length_xor_frame_parser.sv =====
// Results: an error or empty-payload result is registered on the edge that takes the
//   checksum or faulting byte; each payload result is first read from the store and then
//   registered to the output once the output is free, one payload byte after another.
// Throughput: one byte per cycle while parsing, unless a held output result is stalled;
//   input also stalls while the N payload bytes are read back from the store.
// Reset: asynchronous, active low; clears the parser state, start value and output valid.
`timescale 1ns / 1ps
`default_nettype none

module sof_length_xor_frame_parser
    import slxfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    input  wire logic       buffer_start,
    input  wire logic       buffer_end,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [2:0]      status,
    output logic [7:0]      frame_type,
    output logic [5:0]      payload_count,
    output logic [7:0]      data_byte,
    output logic [4:0]      byte_index,
    output logic            byte_valid,
    output logic [7:0]      check_value,
    output logic [5:0]      frame_length,
    output logic            last
);

    cmd_t  cmd;
    stat_t stat;

    slxfp_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .buffer_start (buffer_start),
        .buffer_end   (buffer_end),
        .stat         (stat),
        .in_stall     (in_stall),
        .cmd          (cmd)
    );

    slxfp_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .rx_byte       (rx_byte),
        .out_stall     (out_stall),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (out_valid),
        .status        (status),
        .frame_type    (frame_type),
        .payload_count (payload_count),
        .data_byte     (data_byte),
        .byte_index    (byte_index),
        .byte_valid    (byte_valid),
        .check_value   (check_value),
        .frame_length  (frame_length),
        .last          (last)
    );

endmodule

`default_nettype wire

// ===== sv/slxfp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module slxfp_checker
    import slxfp_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [2:0] status,
    input wire logic [5:0] payload_count,
    input wire logic [7:0] data_byte,
    input wire logic [4:0] byte_index,
    input wire logic       byte_valid,
    input wire logic [5:0] frame_length,
    input wire logic       last
);

    // stalled transfer holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(data_byte) && $stable(status)
            && $stable(byte_index) && $stable(last))
        else $error("output changed while stalled");

    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> last && !byte_valid && (frame_length == 6'd0))
        else $error("malformed error result");

    a_ok_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_OK)
            |-> frame_length == 6'(payload_count + 6'(FRAME_OVERHEAD)))
        else $error("frame length mismatch");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_OK) && byte_valid && last
            |-> byte_index == 5'(payload_count - 6'd1))
        else $error("last payload byte index mismatch");

endmodule

bind sof_length_xor_frame_parser slxfp_checker u_slxfp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .payload_count (payload_count),
    .data_byte     (data_byte),
    .byte_index    (byte_index),
    .byte_valid    (byte_valid),
    .frame_length  (frame_length),
    .last          (last)
);

`default_nettype wire
